@@ hdl/swrm_pkg.sv @@
// Shared types and constants for the sliding window rate meter.
// No dependencies; imported by swrm_rem_unit and sliding_window_rate_meter_unit.
package swrm_pkg;

  localparam int TICK_W   = 64;
  localparam int AMOUNT_W = 32;
  localparam int RES_W    = 32;
  localparam int HIST_W   = 5;
  localparam int SUM_W    = 48;
  localparam int TOTAL_W  = 64;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = TICK_W + AMOUNT_W;
  localparam int OUT_TDATA_W = SUM_W + TOTAL_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIST_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = CFG_IDX_W'(1);

  // Register values after reset
  localparam logic [HIST_W-1:0] HIST_SIZE_RST  = HIST_W'(10);
  localparam logic [RES_W-1:0]  RESOLUTION_RST = RES_W'(100);

  // Request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [RES_W-1:0]  divisor;
  } rem_req_t;

  // Answer from the remainder unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] rem;
  } rem_rsp_t;

endpackage

@@ hdl/swrm_rem_unit.sv @@
// Bit-serial restoring remainder: 64-bit dividend modulo 32-bit divisor.
// Depends on swrm_pkg for the request and answer structs.
module swrm_rem_unit
  import swrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  localparam int STEP_W = $clog2(TICK_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [TICK_W-1:0] dividend;
  logic [RES_W-1:0]  divisor;
  logic [RES_W-1:0]  rem;
  logic [RES_W:0]    trial;

  // One quotient bit a cycle: shift in the next dividend bit, drop the divisor if it fits
  assign trial = {rem, dividend[TICK_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy     <= 1'b1;
        step     <= '0;
        dividend <= req.dividend;
        divisor  <= req.divisor;
        rem      <= '0;
      end else if (busy) begin
        dividend <= dividend << 1;
        if (trial >= {1'b0, divisor}) begin
          rem <= RES_W'(trial - {1'b0, divisor});
        end else begin
          rem <= RES_W'(trial);
        end
        step <= step + 1'b1;
        if (step == STEP_W'(TICK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("remainder done without a running division");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor)
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (busy && step != STEP_W'(TICK_W - 1)) |=> busy)
    else $error("division ended early");

endmodule

@@ hdl/sliding_window_rate_meter_unit.sv @@
// Top level of the sliding window rate meter: sequencer, bucket ring memory, output register.
// Depends on swrm_pkg and swrm_rem_unit.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  s_axis  | in        | s_axis_tvalid/tready     | tick [63:0], amount [95:64]
//  m_axis  | out       | m_axis_tvalid/tready     | window_sum [47:0], total_amount [111:48]
//  cfg     | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data (always ready)
//
// One beat is worked on at a time. A beat that stays in the open bucket goes
// from S_GAP through S_BRANCH to S_DONE, which loads the output register. A beat
// that closes buckets makes P pushes in S_PUSH (P at most the clamped window
// length less 2); a push that finds the ring full first evicts the oldest entry
// (head read in S_PUSH, then subtract in S_EVICT) on the ring memory port. A beat
// that overruns the window waits in S_DIV for the bit-serial remainder by resolution.
// Reset is synchronous and needs no clearing pass; the ring is tracked by head and
// count. A result waiting in the output register does not block the next input beat;
// only the hand-over of a newer result waits for m_axis_tready.
module sliding_window_rate_meter_unit
  import swrm_pkg::*;
#(
  parameter int MAX_BUCKETS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // tick [63:0], amount [95:64]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // window_sum [47:0], total_amount [111:48]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Ring index and entry count share one width: the count never passes MAX_BUCKETS-1
  localparam int CW     = $clog2(MAX_BUCKETS);
  localparam int HW     = $clog2(MAX_BUCKETS + 1);
  localparam int SPAN_W = CW + RES_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_BRANCH,
    S_DIV,
    S_PUSH,
    S_EVICT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [HIST_W-1:0] hist_size;
  logic [RES_W-1:0]  resolution;

  // Meter state kept in flip-flops
  logic [CW-1:0]      ring_head;
  logic [CW-1:0]      ring_count;
  logic [SUM_W-1:0]   recent_bucket;
  logic [SUM_W-1:0]   running_window;
  logic [TOTAL_W-1:0] grand_total;
  logic [TICK_W-1:0]  bucket_start;

  // Per-beat working registers
  logic [TICK_W-1:0]   tick_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic [RES_W-1:0]    res_r;
  logic [CW-1:0]       cap_r;
  logic [TICK_W-1:0]   gap;
  logic [SPAN_W-1:0]   span;
  logic                first_push;

  // Closed bucket ring
  logic [SUM_W-1:0] bucket_history [MAX_BUCKETS];
  logic [SUM_W-1:0] rd_data;
  logic             mem_we;
  logic [CW-1:0]    mem_wa;
  logic [SUM_W-1:0] mem_wd;
  logic [CW:0]      wr_sum;

  logic              evict_now;
  logic [TICK_W-1:0] gap_less;
  logic [HW-1:0]     h_clamp;
  logic [HW-1:0]     h_eff;
  logic [CW-1:0]     head_inc;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  swrm_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // Window length counting the open bucket, held to 1..MAX_BUCKETS
  assign h_clamp = (32'(hist_size) > MAX_BUCKETS) ? HW'(MAX_BUCKETS) : HW'(hist_size);
  assign h_eff   = (h_clamp == '0) ? HW'(1) : h_clamp;

  // A push that finds the ring at capacity first evicts the oldest entry
  assign evict_now = (ring_count != '0) && (ring_count >= cap_r);
  assign gap_less  = gap - TICK_W'(res_r);

  assign wr_sum   = {1'b0, ring_head} + {1'b0, ring_count};
  assign mem_wa   = (wr_sum >= (CW+1)'(MAX_BUCKETS)) ? CW'(wr_sum - (CW+1)'(MAX_BUCKETS))
                                                     : CW'(wr_sum);
  assign mem_we   = (state == S_PUSH) && !evict_now;
  assign mem_wd   = first_push ? recent_bucket : '0;
  assign head_inc = (ring_head == CW'(MAX_BUCKETS - 1)) ? '0 : ring_head + 1'b1;

  assign rem_req.start    = (state == S_BRANCH) && (gap > TICK_W'(span));
  assign rem_req.dividend = gap;
  assign rem_req.divisor  = res_r;

  // Ring memory: one write port, one registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bucket_history[mem_wa] <= mem_wd;
    end
    if (state == S_PUSH && evict_now) begin
      rd_data <= bucket_history[ring_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      hist_size      <= HIST_SIZE_RST;
      resolution     <= RESOLUTION_RST;
      ring_head      <= '0;
      ring_count     <= '0;
      recent_bucket  <= '0;
      running_window <= '0;
      grand_total    <= '0;
      bucket_start   <= '0;
      m_axis_tvalid  <= 1'b0;
      first_push     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HIST_SIZE) begin
          hist_size <= cfg_data[HIST_W-1:0];
        end else if (cfg_index == REG_RESOLUTION) begin
          resolution <= cfg_data[RES_W-1:0];
        end
      end

      // In S_DONE the hand-over itself decides the output valid
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            tick_r   <= s_axis_tdata[TICK_W-1:0];
            amount_r <= s_axis_tdata[TICK_W +: AMOUNT_W];
            res_r    <= (resolution == '0) ? RES_W'(1) : resolution;
            cap_r    <= CW'(h_eff - 1'b1);
            state    <= S_GAP;
          end
        end
        S_GAP: begin
          // Time running backwards counts as no gap
          gap   <= (tick_r > bucket_start) ? tick_r - bucket_start : '0;
          span  <= cap_r * res_r;
          state <= S_BRANCH;
        end
        S_BRANCH: begin
          if (gap > TICK_W'(span)) begin
            state <= S_DIV;
          end else if (gap > TICK_W'(res_r)) begin
            first_push <= 1'b1;
            state      <= S_PUSH;
          end else begin
            recent_bucket  <= recent_bucket + SUM_W'(amount_r);
            running_window <= running_window + SUM_W'(amount_r);
            state          <= S_DONE;
          end
        end
        S_DIV: begin
          // Whole window overrun: align start down to the tick less gap modulo resolution, restart
          if (rem_rsp.done) begin
            bucket_start   <= tick_r - TICK_W'(rem_rsp.rem);
            ring_head      <= '0;
            ring_count     <= '0;
            recent_bucket  <= SUM_W'(amount_r);
            running_window <= SUM_W'(amount_r);
            state          <= S_DONE;
          end
        end
        S_PUSH: begin
          if (evict_now) begin
            state <= S_EVICT;
          end else begin
            ring_count   <= ring_count + 1'b1;
            first_push   <= 1'b0;
            bucket_start <= bucket_start + TICK_W'(res_r);
            gap          <= gap_less;
            if (!(gap_less > TICK_W'(res_r))) begin
              recent_bucket  <= SUM_W'(amount_r);
              running_window <= running_window + SUM_W'(amount_r);
              state          <= S_DONE;
            end
          end
        end
        S_EVICT: begin
          running_window <= running_window - rd_data;
          ring_head      <= head_inc;
          ring_count     <= ring_count - 1'b1;
          state          <= S_PUSH;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            grand_total   <= grand_total + TOTAL_W'(amount_r);
            m_axis_tdata  <= {grand_total + TOTAL_W'(amount_r), running_window};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_EVICT |-> ring_count != '0)
    else $error("eviction from an empty ring");

  a_overrun_clears_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && rem_rsp.done) |=> (ring_count == '0 && ring_head == '0))
    else $error("ring not cleared after window overrun");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while one is in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the hand-over step");

  a_div_only_overrun: assert property (@(posedge clk) disable iff (rst)
    rem_rsp.busy |-> state == S_DIV)
    else $error("remainder unit running outside the overrun path");

endmodule
